>>> rtl/canonical_line_discipline_assert.svh
// Assertion macros shared by the checker of the line discipline.
`ifndef CANONICAL_LINE_DISCIPLINE_ASSERT_SVH
`define CANONICAL_LINE_DISCIPLINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CLD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line discipline assertion failed");

// next-cycle implication, disabled in reset
`define CLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line discipline assertion failed");

// next-cycle implication that also holds across reset
`define CLD_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("line discipline assertion failed");

`endif

>>> rtl/cld_pkg.sv
// Types and constants of the canonical line discipline.
package cld_pkg;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   localparam logic [2:0] OP_TYPED  = 3'd0;
   localparam logic [2:0] OP_READ   = 3'd1;
   localparam logic [2:0] OP_INJECT = 3'd2;
   localparam logic [2:0] OP_FLUSH  = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [2:0] KIND_ECHO  = 3'd0;
   localparam logic [2:0] KIND_DATA  = 3'd1;
   localparam logic [2:0] KIND_EOF   = 3'd2;
   localparam logic [2:0] KIND_EMPTY = 3'd3;
   localparam logic [2:0] KIND_INTR  = 3'd4;

   localparam logic [2:0] REG_CANONICAL = 3'd0;
   localparam logic [2:0] REG_ECHO      = 3'd1;
   localparam logic [2:0] REG_SIGNAL    = 3'd2;
   localparam logic [2:0] REG_INTR_CHAR = 3'd3;
   localparam logic [2:0] REG_EOF_CHAR  = 3'd4;

   localparam logic [7:0] RESET_INTR_CHAR = 8'h03;
   localparam logic [7:0] RESET_EOF_CHAR  = 8'h04;

   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_TAG     = 8'h80;
   localparam logic [7:0] CHAR_BS      = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

endpackage

>>> rtl/cld_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cld_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/canonical_line_discipline.sv
// Canonical line discipline: line editor and read ring around two RAMs.
//
// Channels: req (op, data_byte) carries typed bytes, reads, injects,
// flushes and clears; rsp (kind, out_byte, last) carries echoes, read
// bytes, read status and interrupt events, with last set on the final
// result of an item; csr writes one of five configuration registers
// by index. Items are taken one at a time. Raw, inject, flush and clear
// items and typed bytes that echo nothing finish in the accept; echoed
// bytes, interrupts and end-of-file or empty reads go on to emit a
// result; a read that returns data emits after the registered ring RAM
// read. Back-space reads and checks the line RAM once per removed byte,
// then emits its echo results. A line flush (newline or end-of-file)
// copies the line RAM into the ring RAM at one byte a cycle.
// Results leave through an output register, so the next item is taken
// while a result waits; a stalled receiver holds back only an item that
// needs to emit. Reset clears the length, pointers, end-of-file mark and
// registers to their defaults; the RAM contents are left as they are and
// need no clearing pass.
module canonical_line_discipline #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cld_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cld_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_data
);

   import cld_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam logic [AW:0]   LEN_D   = (AW+1)'(BUFFER_DEPTH);
   localparam logic [AW:0]   PTR_MAX = (AW+1)'(2*BUFFER_DEPTH - 1);
   localparam logic [AW+1:0] CNT_D   = (AW+2)'(BUFFER_DEPTH);
   localparam logic [AW+1:0] TWO_D   = (AW+2)'(2*BUFFER_DEPTH);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_BS_RD   = 3'd1;
   localparam logic [2:0] S_BS_CHK  = 3'd2;
   localparam logic [2:0] S_RD_WAIT = 3'd3;
   localparam logic [2:0] S_EMIT    = 3'd4;
   localparam logic [2:0] S_MOVE    = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [AW:0] len_ff, len_in;
   logic [AW:0] wp_ff, wp_in;
   logic [AW:0] rp_ff, rp_in;
   logic        eof_ff, eof_in;
   logic        canon_ff, echo_ff, sig_ff;
   logic [7:0]  intr_char_ff, eof_char_ff;
   logic [2:0]  em_kind_ff, em_kind_in;
   logic [7:0]  em_byte_ff, em_byte_in;
   logic        em_bs_ff, em_bs_in;
   logic [1:0]  em_total_ff, em_total_in;
   logic [1:0]  em_idx_ff, em_idx_in;
   logic        em_move_ff, em_move_in;
   logic [AW:0] mv_cnt_ff, mv_cnt_in;
   logic        mv_vld_ff, mv_vld_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [AW+1:0] ring_cnt;
   logic          ring_full, ring_empty;
   logic [AW:0]   wp_next, rp_next, wp_wrap, rp_wrap, len_dec;
   logic          push_req;
   logic [7:0]    push_data;
   logic          em_last;
   logic [7:0]    em_out_byte;

   logic          line_we, line_re, ring_we, ring_re;
   logic [AW-1:0] line_waddr, line_raddr, ring_raddr;
   logic [7:0]    line_wdata, line_rdata, ring_rdata;

   cld_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_en   (line_re),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   cld_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_wrap[AW-1:0]),
      .wr_data (push_data),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   always_comb begin
      if (wp_ff >= rp_ff) begin
         ring_cnt = {1'b0, wp_ff} - {1'b0, rp_ff};
      end else begin
         ring_cnt = {1'b0, wp_ff} + TWO_D - {1'b0, rp_ff};
      end
      ring_full  = (ring_cnt >= CNT_D);
      ring_empty = (ring_cnt == '0);
      wp_next    = (wp_ff == PTR_MAX) ? '0 : wp_ff + 1'b1;
      rp_next    = (rp_ff == PTR_MAX) ? '0 : rp_ff + 1'b1;
      wp_wrap    = (wp_ff >= LEN_D) ? wp_ff - LEN_D : wp_ff;
      rp_wrap    = (rp_ff >= LEN_D) ? rp_ff - LEN_D : rp_ff;
      len_dec    = len_ff - 1'b1;
      em_last    = (em_idx_ff == em_total_ff - 2'd1);
      if (em_bs_ff) begin
         em_out_byte = (em_idx_ff == 2'd1) ? CHAR_SPACE : CHAR_BS;
      end else begin
         em_out_byte = em_byte_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      eof_in       = eof_ff;
      em_kind_in   = em_kind_ff;
      em_byte_in   = em_byte_ff;
      em_bs_in     = em_bs_ff;
      em_total_in  = em_total_ff;
      em_idx_in    = em_idx_ff;
      em_move_in   = em_move_ff;
      mv_cnt_in    = mv_cnt_ff;
      mv_vld_in    = mv_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      push_req     = 1'b0;
      push_data    = req_payload.data_byte;
      line_we      = 1'b0;
      line_waddr   = len_ff[AW-1:0];
      line_wdata   = req_payload.data_byte;
      line_re      = 1'b0;
      line_raddr   = len_dec[AW-1:0];
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      ring_raddr   = rp_wrap[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               em_idx_in   = 2'd0;
               em_bs_in    = 1'b0;
               em_total_in = 2'd1;
               em_move_in  = 1'b0;
               em_byte_in  = 8'h00;
               mv_cnt_in   = '0;
               mv_vld_in   = 1'b0;
               case (req_payload.op)
                  OP_TYPED: begin
                     if (!canon_ff) begin
                        push_req = 1'b1;
                     end else if (sig_ff && req_payload.data_byte == intr_char_ff) begin
                        len_in     = '0;
                        em_kind_in = KIND_INTR;
                        state_in   = S_EMIT;
                     end else if (req_payload.data_byte == CHAR_BS) begin
                        if (len_ff != '0) begin
                           state_in = S_BS_RD;
                        end
                     end else if (req_payload.data_byte == eof_char_ff) begin
                        if (len_ff == '0) begin
                           eof_in = 1'b1;
                        end else begin
                           state_in = S_MOVE;
                        end
                     end else if (req_payload.data_byte == CHAR_NEWLINE) begin
                        if (len_ff < LEN_D) begin
                           line_we = 1'b1;
                           len_in  = len_ff + 1'b1;
                        end
                        if (echo_ff) begin
                           em_kind_in = KIND_ECHO;
                           em_byte_in = CHAR_NEWLINE;
                           em_move_in = 1'b1;
                           state_in   = S_EMIT;
                        end else begin
                           state_in = S_MOVE;
                        end
                     end else if (len_ff < LEN_D) begin
                        line_we = 1'b1;
                        len_in  = len_ff + 1'b1;
                        if (echo_ff) begin
                           em_kind_in = KIND_ECHO;
                           em_byte_in = req_payload.data_byte;
                           state_in   = S_EMIT;
                        end
                     end
                  end
                  OP_READ: begin
                     if (!ring_empty) begin
                        ring_re  = 1'b1;
                        state_in = S_RD_WAIT;
                     end else if (eof_ff) begin
                        eof_in     = 1'b0;
                        em_kind_in = KIND_EOF;
                        state_in   = S_EMIT;
                     end else begin
                        em_kind_in = KIND_EMPTY;
                        state_in   = S_EMIT;
                     end
                  end
                  OP_INJECT: begin
                     push_req = 1'b1;
                  end
                  OP_FLUSH: begin
                     wp_in  = '0;
                     rp_in  = '0;
                     eof_in = 1'b0;
                     len_in = '0;
                  end
                  OP_CLEAR: begin
                     len_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BS_RD: begin
            line_re  = 1'b1;
            state_in = S_BS_CHK;
         end
         S_BS_CHK: begin
            len_in = len_dec;
            if ((line_rdata & CONT_MASK) == CONT_TAG && len_dec != '0) begin
               state_in = S_BS_RD;
            end else if (echo_ff) begin
               em_kind_in  = KIND_ECHO;
               em_bs_in    = 1'b1;
               em_total_in = 2'd3;
               state_in    = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD_WAIT: begin
            em_kind_in = KIND_DATA;
            em_byte_in = ring_rdata;
            rp_in      = rp_next;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.kind     = em_kind_ff;
               rsp_data_in.out_byte = em_out_byte;
               rsp_data_in.last     = em_last;
               em_idx_in            = em_idx_ff + 2'd1;
               if (em_last) begin
                  state_in = em_move_ff ? S_MOVE : S_IDLE;
               end
            end
         end
         S_MOVE: begin
            push_data = line_rdata;
            push_req  = mv_vld_ff;
            line_raddr = mv_cnt_ff[AW-1:0];
            if (mv_cnt_ff < len_ff) begin
               line_re   = 1'b1;
               mv_cnt_in = mv_cnt_ff + 1'b1;
               mv_vld_in = 1'b1;
            end else begin
               mv_vld_in = 1'b0;
               if (!mv_vld_ff) begin
                  len_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_req && !ring_full) begin
         ring_we = 1'b1;
         wp_in   = wp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         eof_ff       <= 1'b0;
         mv_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         canon_ff     <= 1'b1;
         echo_ff      <= 1'b1;
         sig_ff       <= 1'b1;
         intr_char_ff <= RESET_INTR_CHAR;
         eof_char_ff  <= RESET_EOF_CHAR;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         eof_ff       <= eof_in;
         mv_vld_ff    <= mv_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_CANONICAL: canon_ff     <= csr_data[0];
               REG_ECHO:      echo_ff      <= csr_data[0];
               REG_SIGNAL:    sig_ff       <= csr_data[0];
               REG_INTR_CHAR: intr_char_ff <= csr_data;
               REG_EOF_CHAR:  eof_char_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      em_kind_ff  <= em_kind_in;
      em_byte_ff  <= em_byte_in;
      em_bs_ff    <= em_bs_in;
      em_total_ff <= em_total_in;
      em_idx_ff   <= em_idx_in;
      em_move_ff  <= em_move_in;
      mv_cnt_ff   <= mv_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

>>> rtl/cld_checker.sv
// Port-level checker of the line discipline, bound to the top level.
`include "canonical_line_discipline_assert.svh"

module cld_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cld_pkg::rsp_type rsp_payload
);

   import cld_pkg::*;

   `CLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `CLD_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && req_ready)
   `CLD_ASSERT_SAME(a_no_accept_mid_item, clock, reset, rsp_valid && !rsp_payload.last, !req_ready)
   `CLD_ASSERT_SAME(a_status_single, clock, reset, rsp_valid && rsp_payload.kind != KIND_ECHO && rsp_payload.kind != KIND_DATA, rsp_payload.last && rsp_payload.out_byte == 8'h00)

endmodule

bind canonical_line_discipline cld_checker u_cld_checker (.*);
